FILE: src/ipv4fd_pkg.sv
// ipv4fd_pkg: shared types and constants of the ipv4 forwarding decision block
// used by ipv4fd_lpm_scan and ipv4_forward_decision_lpm; depends on nothing else
package ipv4fd_pkg;

    // default sizes of the route table and the interface table
    localparam int ROUTE_ENTRIES_DEF = 16;
    localparam int PORTS_DEF         = 4;

    // input item modes
    localparam logic [1:0] MODE_ROUTE_WR = 2'd0;
    localparam logic [1:0] MODE_PORT_WR  = 2'd1;
    localparam logic [1:0] MODE_PACKET   = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // result actions
    localparam logic [2:0] ACT_ACK     = 3'd0;
    localparam logic [2:0] ACT_BADHDR  = 3'd1;
    localparam logic [2:0] ACT_FORWARD = 3'd2;
    localparam logic [2:0] ACT_TIMEX   = 3'd3;
    localparam logic [2:0] ACT_NETUNR  = 3'd4;
    localparam logic [2:0] ACT_ECHO    = 3'd5;
    localparam logic [2:0] ACT_PORTUNR = 3'd6;
    localparam logic [2:0] ACT_DROP    = 3'd7;

    // header constants
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [1:0] ICMP_ECHO_REQ = 2'd1;
    localparam logic [7:0] REPLY_TTL  = 8'd64;

    // configuration register indexes
    localparam logic CFG_ROUTE_COUNT = 1'b0;
    localparam logic CFG_PORT_COUNT  = 1'b1;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [1:0]  port;
    } route_entry_t;

    typedef struct packed {
        logic        start;
        logic [31:0] key;
    } lpm_req_t;

    typedef struct packed {
        logic        done;
        logic        found;
        logic [31:0] gateway;
        logic [1:0]  port;
    } lpm_res_t;

endpackage

FILE: src/ipv4fd_lpm_scan.sv
// ipv4fd_lpm_scan: route table memory and longest prefix match scanner
// one entry read per cycle from a synchronous memory; depends on ipv4fd_pkg
module ipv4fd_lpm_scan #(
    parameter int ROUTE_ENTRIES = ipv4fd_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [3:0]               wr_index,
    input  ipv4fd_pkg::route_entry_t wr_entry,
    input  logic [4:0]               route_count,
    input  ipv4fd_pkg::lpm_req_t     req,
    output ipv4fd_pkg::lpm_res_t     res
);
    localparam int RIDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ROUTE_ENTRIES + 1);

    ipv4fd_pkg::route_entry_t route_mem [ROUTE_ENTRIES];
    ipv4fd_pkg::route_entry_t rdata_reg;

    logic              busy_reg, busy_next;
    logic              pend_reg, pend_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [31:0]       key_reg, key_next;
    logic [31:0]       best_mask_reg, best_mask_next;
    logic [31:0]       gw_reg, gw_next;
    logic [1:0]        port_reg, port_next;

    logic [CNT_W-1:0]  used;
    logic              rd_en;
    logic              hit;
    logic              scan_done;
    logic              wr_ok;

    always_comb begin
        if (32'(route_count) > ROUTE_ENTRIES) begin
            used = CNT_W'(ROUTE_ENTRIES);
        end else begin
            used = CNT_W'(route_count);
        end
    end

    assign wr_ok     = wr_en && (32'(wr_index) < ROUTE_ENTRIES);
    assign rd_en     = busy_reg && (cnt_reg != n_reg);
    assign hit       = ((key_reg & rdata_reg.mask) == rdata_reg.dest);
    assign scan_done = busy_reg && !rd_en && !pend_reg;

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            route_mem[RIDX_W'(wr_index)] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= route_mem[cnt_reg[RIDX_W-1:0]];
        end
    end

    always_comb begin
        busy_next      = busy_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        key_next       = key_reg;
        best_mask_next = best_mask_reg;
        gw_next        = gw_reg;
        port_next      = port_reg;
        if (req.start) begin
            busy_next      = 1'b1;
            pend_next      = 1'b0;
            found_next     = 1'b0;
            cnt_next       = '0;
            n_next         = used;
            key_next       = req.key;
            best_mask_next = '0;
        end else if (busy_reg) begin
            pend_next = rd_en;
            if (rd_en) begin
                cnt_next = cnt_reg + 1'b1;
            end
            // strictly larger mask wins, so ties keep the earliest entry
            if (pend_reg && hit && (!found_reg || rdata_reg.mask > best_mask_reg)) begin
                found_next     = 1'b1;
                best_mask_next = rdata_reg.mask;
                gw_next        = rdata_reg.gateway;
                port_next      = rdata_reg.port;
            end
            if (scan_done) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
            n_reg     <= '0;
        end else begin
            busy_reg  <= busy_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        best_mask_reg <= best_mask_next;
        gw_reg        <= gw_next;
        port_reg      <= port_next;
    end

    assign res.done    = scan_done;
    assign res.found   = found_reg;
    assign res.gateway = gw_reg;
    assign res.port    = port_reg;

endmodule

FILE: src/ipv4_forward_decision_lpm.sv
// ipv4_forward_decision_lpm: top level of the ipv4 forwarding decision block
// holds the sequencer, interface addresses and result register; uses
// ipv4fd_pkg and ipv4fd_lpm_scan
//
//  channel | direction | ports                       | accepted when
//  --------+-----------+-----------------------------+----------------------
//  s_      | in        | s_valid s_ready + 12 fields | s_valid && s_ready
//  m_      | out       | m_valid m_ready + 6 fields  | m_valid && m_ready
//  cfg_    | in        | cfg_valid cfg_ready, index  | cfg_valid && cfg_ready
//
// one item at a time: writes and simple packets pass the decide and done
// states, and a packet that needs a route scan also the scan state, for the
// destination scan, the source scan or both over the routes in use; the
// scan reads one route entry per cycle from the route memory.
// reset clears control state only; the route and interface tables are
// undefined until written. a result waiting on m_ready does not block the
// next item until that item's own result is ready.
module ipv4_forward_decision_lpm #(
    parameter int ROUTE_ENTRIES = ipv4fd_pkg::ROUTE_ENTRIES_DEF,
    parameter int PORTS         = ipv4fd_pkg::PORTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [3:0]  s_index,
    input  logic [31:0] s_entry_address,
    input  logic [31:0] s_route_mask,
    input  logic [31:0] s_route_gateway,
    input  logic [1:0]  s_route_port,
    input  logic [31:0] s_pkt_dst,
    input  logic [31:0] s_pkt_src,
    input  logic [7:0]  s_pkt_ttl,
    input  logic [7:0]  s_pkt_proto,
    input  logic        s_header_sum_ok,
    input  logic [1:0]  s_icmp_kind,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [1:0]  m_out_port,
    output logic [31:0] m_next_hop,
    output logic [31:0] m_reply_src_ip,
    output logic [7:0]  m_new_ttl,
    output logic        m_no_source_route,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    localparam int PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  route_count_reg;
    logic [2:0]  port_count_reg;
    logic [31:0] port_addr_reg [PORTS];

    // latched input item
    logic [1:0]  mode_reg;
    logic [3:0]  index_reg;
    logic [31:0] dst_reg;
    logic [31:0] src_reg;
    logic [7:0]  ttl_reg;
    logic [7:0]  proto_reg;
    logic        sum_ok_reg;
    logic [1:0]  kind_reg;

    logic        phase_src_reg, phase_src_next;
    logic [2:0]  err_act_reg, err_act_next;

    logic [2:0]  res_action_reg, res_action_next;
    logic [1:0]  res_port_reg, res_port_next;
    logic [31:0] res_hop_reg, res_hop_next;
    logic [31:0] res_src_reg, res_src_next;
    logic [7:0]  res_ttl_reg, res_ttl_next;
    logic        res_nosrc_reg, res_nosrc_next;

    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_action_reg;
    logic [1:0]  m_port_reg;
    logic [31:0] m_hop_reg;
    logic [31:0] m_src_reg;
    logic [7:0]  m_ttl_reg;
    logic        m_nosrc_reg;

    logic        in_acc;
    logic        out_load;
    logic        own;
    logic        src_port_ok;
    logic [31:0] src_port_addr;

    ipv4fd_pkg::route_entry_t wr_entry;
    ipv4fd_pkg::lpm_req_t     scan_req;
    ipv4fd_pkg::lpm_res_t     scan_res;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_count_reg <= '0;
            port_count_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                ipv4fd_pkg::CFG_ROUTE_COUNT: route_count_reg <= cfg_data;
                ipv4fd_pkg::CFG_PORT_COUNT:  port_count_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // interface address table, written straight from the accepted item
    always_ff @(posedge aclk) begin
        if (in_acc && s_mode == ipv4fd_pkg::MODE_PORT_WR && 32'(s_index) < PORTS) begin
            port_addr_reg[PIDX_W'(s_index)] <= s_entry_address;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            mode_reg   <= s_mode;
            index_reg  <= s_index;
            dst_reg    <= s_pkt_dst;
            src_reg    <= s_pkt_src;
            ttl_reg    <= s_pkt_ttl;
            proto_reg  <= s_pkt_proto;
            sum_ok_reg <= s_header_sum_ok;
            kind_reg   <= s_icmp_kind;
        end
    end

    assign wr_entry.dest    = s_entry_address;
    assign wr_entry.mask    = s_route_mask;
    assign wr_entry.gateway = s_route_gateway;
    assign wr_entry.port    = s_route_port;

    ipv4fd_lpm_scan #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_lpm_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (in_acc && s_mode == ipv4fd_pkg::MODE_ROUTE_WR),
        .wr_index    (s_index),
        .wr_entry    (wr_entry),
        .route_count (route_count_reg),
        .req         (scan_req),
        .res         (scan_res)
    );

    // destination is one of our own interface addresses
    always_comb begin
        own = 1'b0;
        for (int i = 0; i < PORTS; i++) begin
            if (32'(i) < 32'(port_count_reg) && port_addr_reg[i] == dst_reg) begin
                own = 1'b1;
            end
        end
    end

    assign src_port_ok   = (32'(scan_res.port) < PORTS) && ({1'b0, scan_res.port} < port_count_reg);
    assign src_port_addr = src_port_ok ? port_addr_reg[PIDX_W'(scan_res.port)] : '0;

    always_comb begin
        state_next      = state_reg;
        phase_src_next  = phase_src_reg;
        err_act_next    = err_act_reg;
        res_action_next = res_action_reg;
        res_port_next   = res_port_reg;
        res_hop_next    = res_hop_reg;
        res_src_next    = res_src_reg;
        res_ttl_next    = res_ttl_reg;
        res_nosrc_next  = res_nosrc_reg;
        scan_req.start  = 1'b0;
        scan_req.key    = src_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_action_next = ipv4fd_pkg::ACT_DROP;
                res_port_next   = '0;
                res_hop_next    = '0;
                res_src_next    = '0;
                res_ttl_next    = '0;
                res_nosrc_next  = 1'b0;
                state_next      = ST_DONE;
                if (mode_reg == ipv4fd_pkg::MODE_ROUTE_WR || mode_reg == ipv4fd_pkg::MODE_PORT_WR) begin
                    res_action_next = ipv4fd_pkg::ACT_ACK;
                end else if (mode_reg == ipv4fd_pkg::MODE_UNUSED) begin
                    res_action_next = ipv4fd_pkg::ACT_DROP;
                end else if (!sum_ok_reg) begin
                    res_action_next = ipv4fd_pkg::ACT_BADHDR;
                end else if (own) begin
                    if (proto_reg == ipv4fd_pkg::PROTO_ICMP) begin
                        if (kind_reg == ipv4fd_pkg::ICMP_ECHO_REQ) begin
                            res_action_next = ipv4fd_pkg::ACT_ECHO;
                            res_port_next   = index_reg[1:0];
                            res_src_next    = dst_reg;
                            res_ttl_next    = ipv4fd_pkg::REPLY_TTL;
                        end
                    end else if (proto_reg == ipv4fd_pkg::PROTO_TCP
                                 || proto_reg == ipv4fd_pkg::PROTO_UDP) begin
                        scan_req.start = 1'b1;
                        phase_src_next = 1'b1;
                        err_act_next   = ipv4fd_pkg::ACT_PORTUNR;
                        state_next     = ST_SCAN;
                    end
                end else if (ttl_reg <= 8'd1) begin
                    scan_req.start = 1'b1;
                    phase_src_next = 1'b1;
                    err_act_next   = ipv4fd_pkg::ACT_TIMEX;
                    state_next     = ST_SCAN;
                end else begin
                    scan_req.start = 1'b1;
                    scan_req.key   = dst_reg;
                    phase_src_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_res.done) begin
                    if (!phase_src_reg) begin
                        if (scan_res.found) begin
                            res_action_next = ipv4fd_pkg::ACT_FORWARD;
                            res_port_next   = scan_res.port;
                            res_hop_next    = scan_res.gateway;
                            res_ttl_next    = ttl_reg - 8'd1;
                            state_next      = ST_DONE;
                        end else begin
                            // no route to destination, look up the way back
                            scan_req.start = 1'b1;
                            phase_src_next = 1'b1;
                            err_act_next   = ipv4fd_pkg::ACT_NETUNR;
                        end
                    end else begin
                        res_action_next = err_act_reg;
                        res_ttl_next    = ipv4fd_pkg::REPLY_TTL;
                        if (scan_res.found) begin
                            res_port_next = scan_res.port;
                            res_src_next  = src_port_addr;
                        end else begin
                            res_nosrc_next = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_src_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_src_reg <= phase_src_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_act_reg    <= err_act_next;
        res_action_reg <= res_action_next;
        res_port_reg   <= res_port_next;
        res_hop_reg    <= res_hop_next;
        res_src_reg    <= res_src_next;
        res_ttl_reg    <= res_ttl_next;
        res_nosrc_reg  <= res_nosrc_next;
        if (out_load) begin
            m_action_reg <= res_action_reg;
            m_port_reg   <= res_port_reg;
            m_hop_reg    <= res_hop_reg;
            m_src_reg    <= res_src_reg;
            m_ttl_reg    <= res_ttl_reg;
            m_nosrc_reg  <= res_nosrc_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_action          = m_action_reg;
    assign m_out_port        = m_port_reg;
    assign m_next_hop        = m_hop_reg;
    assign m_reply_src_ip    = m_src_reg;
    assign m_new_ttl         = m_ttl_reg;
    assign m_no_source_route = m_nosrc_reg;

    // a scan only finishes while the sequencer waits on it
    a_scan_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_res.done |-> state_reg == ST_SCAN)
        else $error("route scan finished outside the scan state");

    // write acks carry nothing but the action
    a_ack_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ipv4fd_pkg::ACT_ACK |->
            m_next_hop == 32'd0 && m_reply_src_ip == 32'd0 && m_new_ttl == 8'd0
            && !m_no_source_route)
        else $error("write ack with nonzero fields");

    // forwarding only happens with ttl of two or more
    a_fwd_ttl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == ipv4fd_pkg::ACT_FORWARD |-> m_new_ttl != 8'd0)
        else $error("forwarded item with expired ttl");

    // missing source route is only reported on icmp errors
    a_nosrc_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_source_route |->
            m_action == ipv4fd_pkg::ACT_TIMEX || m_action == ipv4fd_pkg::ACT_NETUNR
            || m_action == ipv4fd_pkg::ACT_PORTUNR)
        else $error("no source route flag on a non-error result");

endmodule

FILE: tb/ipv4_forward_decision_lpm_tb.sv
// ipv4_forward_decision_lpm_tb: self-checking testbench for the ipv4 forwarding decision block
// predicts each result from its own copy of the route and interface tables; needs
// ipv4fd_pkg and ipv4_forward_decision_lpm, and through it ipv4fd_lpm_scan
module ipv4_forward_decision_lpm_tb;
    import ipv4fd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  index;
        logic [31:0] entry_address;
        logic [31:0] route_mask;
        logic [31:0] route_gateway;
        logic [1:0]  route_port;
        logic [31:0] pkt_dst;
        logic [31:0] pkt_src;
        logic [7:0]  pkt_ttl;
        logic [7:0]  pkt_proto;
        logic        header_sum_ok;
        logic [1:0]  icmp_kind;
    } hdr_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  out_port;
        logic [31:0] next_hop;
        logic [31:0] reply_src_ip;
        logic [7:0]  new_ttl;
        logic        no_source_route;
    } decision_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [3:0]  s_index = '0;
    logic [31:0] s_entry_address = '0;
    logic [31:0] s_route_mask = '0;
    logic [31:0] s_route_gateway = '0;
    logic [1:0]  s_route_port = '0;
    logic [31:0] s_pkt_dst = '0;
    logic [31:0] s_pkt_src = '0;
    logic [7:0]  s_pkt_ttl = '0;
    logic [7:0]  s_pkt_proto = '0;
    logic        s_header_sum_ok = 1'b0;
    logic [1:0]  s_icmp_kind = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_action;
    logic [1:0]  m_out_port;
    logic [31:0] m_next_hop;
    logic [31:0] m_reply_src_ip;
    logic [7:0]  m_new_ttl;
    logic        m_no_source_route;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [4:0]  cfg_data = '0;

    // predictor state
    logic [31:0] rt_dest [ROUTE_ENTRIES_DEF];
    logic [31:0] rt_mask [ROUTE_ENTRIES_DEF];
    logic [31:0] rt_gw [ROUTE_ENTRIES_DEF];
    logic [1:0]  rt_port [ROUTE_ENTRIES_DEF];
    logic [31:0] if_addr [PORTS_DEF];
    logic [4:0]  route_cnt = '0;
    logic [2:0]  port_cnt = '0;

    decision_t pending_decisions [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        no_stall = 1'b0;

    ipv4_forward_decision_lpm dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_index           (s_index),
        .s_entry_address   (s_entry_address),
        .s_route_mask      (s_route_mask),
        .s_route_gateway   (s_route_gateway),
        .s_route_port      (s_route_port),
        .s_pkt_dst         (s_pkt_dst),
        .s_pkt_src         (s_pkt_src),
        .s_pkt_ttl         (s_pkt_ttl),
        .s_pkt_proto       (s_pkt_proto),
        .s_header_sum_ok   (s_header_sum_ok),
        .s_icmp_kind       (s_icmp_kind),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_action          (m_action),
        .m_out_port        (m_out_port),
        .m_next_hop        (m_next_hop),
        .m_reply_src_ip    (m_reply_src_ip),
        .m_new_ttl         (m_new_ttl),
        .m_no_source_route (m_no_source_route),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** ipv4_forward_decision_lpm: FAILED **");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_stall || ($urandom_range(99) >= 16);
    end

    // ---------------------------------------------------------------- prediction

    // winner is the numerically largest mask, earliest entry on ties
    function automatic bit longest_match(input logic [31:0] addr, output int hit);
        logic [31:0] best_mask;
        bit          found;
        int          n;
        best_mask = '0;
        found = 1'b0;
        hit = 0;
        n = (route_cnt > ROUTE_ENTRIES_DEF) ? ROUTE_ENTRIES_DEF : route_cnt;
        for (int i = 0; i < n; i++) begin
            if ((addr & rt_mask[i]) == rt_dest[i] && (!found || rt_mask[i] > best_mask)) begin
                found = 1'b1;
                best_mask = rt_mask[i];
                hit = i;
            end
        end
        return found;
    endfunction

    // icmp error goes back along the route to the source
    function automatic decision_t source_error(input logic [2:0] act, input logic [31:0] src);
        decision_t d;
        int        hit;
        int        n_ports;
        d = '0;
        d.action = act;
        d.new_ttl = REPLY_TTL;
        n_ports = (port_cnt > PORTS_DEF) ? PORTS_DEF : port_cnt;
        if (longest_match(src, hit)) begin
            d.out_port = rt_port[hit];
            if (rt_port[hit] < n_ports)
                d.reply_src_ip = if_addr[rt_port[hit]];
        end else begin
            d.no_source_route = 1'b1;
        end
        return d;
    endfunction

    function automatic decision_t predict_decision(input hdr_item_t it);
        decision_t d;
        int        hit;
        int        n_ports;
        bit        own;
        d = '0;
        own = 1'b0;
        n_ports = (port_cnt > PORTS_DEF) ? PORTS_DEF : port_cnt;
        case (it.mode)
            MODE_ROUTE_WR: begin
                rt_dest[it.index] = it.entry_address;
                rt_mask[it.index] = it.route_mask;
                rt_gw[it.index] = it.route_gateway;
                rt_port[it.index] = it.route_port;
                d.action = ACT_ACK;
            end
            MODE_PORT_WR: begin
                if (it.index < PORTS_DEF)
                    if_addr[it.index[1:0]] = it.entry_address;
                d.action = ACT_ACK;
            end
            MODE_PACKET: begin
                if (!it.header_sum_ok) begin
                    d.action = ACT_BADHDR;
                end else begin
                    for (int i = 0; i < n_ports; i++)
                        if (if_addr[i] == it.pkt_dst)
                            own = 1'b1;
                    if (own) begin
                        if (it.pkt_proto == PROTO_ICMP) begin
                            if (it.icmp_kind == ICMP_ECHO_REQ) begin
                                d.action = ACT_ECHO;
                                d.out_port = it.index[1:0];
                                d.reply_src_ip = it.pkt_dst;
                                d.new_ttl = REPLY_TTL;
                            end else begin
                                d.action = ACT_DROP;
                            end
                        end else if (it.pkt_proto == PROTO_TCP || it.pkt_proto == PROTO_UDP) begin
                            d = source_error(ACT_PORTUNR, it.pkt_src);
                        end else begin
                            d.action = ACT_DROP;
                        end
                    end else if (it.pkt_ttl <= 8'd1) begin
                        d = source_error(ACT_TIMEX, it.pkt_src);
                    end else if (longest_match(it.pkt_dst, hit)) begin
                        d.action = ACT_FORWARD;
                        d.out_port = rt_port[hit];
                        d.next_hop = rt_gw[hit];
                        d.new_ttl = it.pkt_ttl - 8'd1;
                    end else begin
                        d = source_error(ACT_NETUNR, it.pkt_src);
                    end
                end
            end
            default: begin
                d.action = ACT_DROP;
            end
        endcase
        return d;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : result_check
        decision_t got;
        decision_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_action, m_out_port, m_next_hop, m_reply_src_ip, m_new_ttl,
                   m_no_source_route};
            if (pending_decisions.size() == 0) begin
                report_mismatch("result with nothing pending, action", got.action, '0);
            end else begin
                want = pending_decisions.pop_front();
                if (got.action !== want.action)
                    report_mismatch("action", got.action, want.action);
                if (got.out_port !== want.out_port)
                    report_mismatch("out_port", got.out_port, want.out_port);
                if (got.next_hop !== want.next_hop)
                    report_mismatch("next_hop", got.next_hop, want.next_hop);
                if (got.reply_src_ip !== want.reply_src_ip)
                    report_mismatch("reply_src_ip", got.reply_src_ip, want.reply_src_ip);
                if (got.new_ttl !== want.new_ttl)
                    report_mismatch("new_ttl", got.new_ttl, want.new_ttl);
                if (got.no_source_route !== want.no_source_route)
                    report_mismatch("no_source_route", got.no_source_route,
                                    want.no_source_route);
            end
        end
    end

    // ---------------------------------------------------------------- item builders

    function automatic hdr_item_t random_item();
        hdr_item_t it;
        it.mode = $urandom_range(3);
        it.index = $urandom_range(15);
        it.entry_address = $urandom;
        it.route_mask = $urandom;
        it.route_gateway = $urandom;
        it.route_port = $urandom_range(3);
        it.pkt_dst = $urandom;
        it.pkt_src = $urandom;
        it.pkt_ttl = $urandom_range(255);
        it.pkt_proto = $urandom_range(255);
        it.header_sum_ok = $urandom_range(1);
        it.icmp_kind = $urandom_range(3);
        return it;
    endfunction

    function automatic hdr_item_t route_item(input logic [3:0] idx,
                                             input logic [31:0] dest, mask, gw,
                                             input logic [1:0] port);
        hdr_item_t it;
        it = random_item();
        it.mode = MODE_ROUTE_WR;
        it.index = idx;
        it.entry_address = dest;
        it.route_mask = mask;
        it.route_gateway = gw;
        it.route_port = port;
        return it;
    endfunction

    function automatic hdr_item_t port_item(input logic [3:0] idx, input logic [31:0] addr);
        hdr_item_t it;
        it = random_item();
        it.mode = MODE_PORT_WR;
        it.index = idx;
        it.entry_address = addr;
        return it;
    endfunction

    function automatic hdr_item_t packet_item(input logic [31:0] dst, src,
                                              input logic [7:0] ttl, proto,
                                              input logic [1:0] kind,
                                              input logic [3:0] arrival,
                                              input logic sum_ok);
        hdr_item_t it;
        it = random_item();
        it.mode = MODE_PACKET;
        it.index = arrival;
        it.pkt_dst = dst;
        it.pkt_src = src;
        it.pkt_ttl = ttl;
        it.pkt_proto = proto;
        it.icmp_kind = kind;
        it.header_sum_ok = sum_ok;
        return it;
    endfunction

    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    // an address under some route in use, anywhere when none is in use
    function automatic logic [31:0] addr_in_route();
        int n;
        int i;
        n = (route_cnt > ROUTE_ENTRIES_DEF) ? ROUTE_ENTRIES_DEF : route_cnt;
        if (n == 0)
            return $urandom;
        i = $urandom_range(n - 1);
        return (rt_dest[i] & rt_mask[i]) | ($urandom & ~rt_mask[i]);
    endfunction

    function automatic hdr_item_t random_route_item();
        logic [31:0] mask;
        logic [31:0] dest;
        if ($urandom_range(99) < 6)
            mask = $urandom;
        else if ($urandom_range(99) < 10)
            mask = prefix_mask($urandom_range(7));
        else
            mask = prefix_mask($urandom_range(32, 8));
        dest = ($urandom_range(99) < 6) ? $urandom : ($urandom & mask);
        return route_item($urandom_range(15), dest, mask, $urandom, $urandom_range(3));
    endfunction

    function automatic hdr_item_t random_packet_item();
        logic [31:0] dst;
        logic [31:0] src;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        int          r;
        r = $urandom_range(99);
        if (r < 30)
            dst = if_addr[$urandom_range(PORTS_DEF - 1)];
        else if (r < 75)
            dst = addr_in_route();
        else
            dst = $urandom;
        src = ($urandom_range(99) < 75) ? addr_in_route() : $urandom;
        ttl = ($urandom_range(99) < 15) ? $urandom_range(2) : $urandom_range(255);
        r = $urandom_range(99);
        if (r < 25)
            proto = PROTO_ICMP;
        else if (r < 50)
            proto = PROTO_TCP;
        else if (r < 70)
            proto = PROTO_UDP;
        else
            proto = $urandom_range(255);
        return packet_item(dst, src, ttl, proto,
                           ($urandom_range(1) ? ICMP_ECHO_REQ : 2'($urandom_range(3))),
                           $urandom_range(15), ($urandom_range(99) < 92));
    endfunction

    function automatic hdr_item_t random_traffic_item();
        int r;
        r = $urandom_range(99);
        if (r < 82)
            return random_packet_item();
        if (r < 91)
            return random_route_item();
        if (r < 96)
            return port_item($urandom_range(15), ($urandom_range(1) ? addr_in_route() : $urandom));
        return random_item();
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input hdr_item_t it);
        while (!no_stall && $urandom_range(99) < 16) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_mode = it.mode;
        s_index = it.index;
        s_entry_address = it.entry_address;
        s_route_mask = it.route_mask;
        s_route_gateway = it.route_gateway;
        s_route_port = it.route_port;
        s_pkt_dst = it.pkt_dst;
        s_pkt_src = it.pkt_src;
        s_pkt_ttl = it.pkt_ttl;
        s_pkt_proto = it.pkt_proto;
        s_header_sum_ok = it.header_sum_ok;
        s_icmp_kind = it.icmp_kind;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_decisions.push_back(predict_decision(it));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [4:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_ROUTE_COUNT)
            route_cnt = value;
        else
            port_cnt = value[2:0];
    endtask

    // counts change only with the block idle
    task automatic set_counts(input logic [4:0] routes, input logic [4:0] ports);
        wait_drained();
        write_register(CFG_ROUTE_COUNT, routes);
        write_register(CFG_PORT_COUNT, ports);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ---------------------------------------------------------------- tests

    // fill both tables while nothing is in use, so no unwritten entry is ever read
    task automatic test_table_load();
        send_item(port_item(4'd0, 32'h0A00_0001));
        send_item(port_item(4'd1, 32'h0A01_0001));
        send_item(port_item(4'd2, 32'hC0A8_0001));
        send_item(port_item(4'd3, 32'hFFFF_FFFF));
        // interface writes past the table are acked and dropped
        send_item(port_item(4'd4, 32'h0808_0808));
        send_item(port_item(4'd15, 32'h0000_0000));
        send_item(route_item(4'd0, 32'h0A00_0000, prefix_mask(8), 32'h0, 2'd0));
        send_item(route_item(4'd1, 32'h0A01_0000, prefix_mask(16), 32'h0A01_00FE, 2'd1));
        send_item(route_item(4'd2, 32'h0A01_0200, prefix_mask(24), 32'h0A01_02FE, 2'd2));
        send_item(route_item(4'd3, 32'h0A01_0203, prefix_mask(32), 32'hFFFF_FFFF, 2'd3));
        // same prefix as entry 1, loses the tie
        send_item(route_item(4'd4, 32'h0A01_0000, prefix_mask(16), 32'h0B0B_0B0B, 2'd3));
        send_item(route_item(4'd5, 32'hC0A8_0000, prefix_mask(16), 32'hC0A8_00FE, 2'd3));
        for (int i = 6; i < 15; i++)
            send_item(route_item(i, {8'd172, 8'(16 + i), 16'h0}, prefix_mask(16),
                                 $urandom, 2'(i)));
        send_item(route_item(4'd15, 32'h0, prefix_mask(0), 32'hC0A8_00FE, 2'd2));
        // unused mode and packets with empty tables
        send_item(packet_item(32'h0A01_0203, 32'h0A00_0005, 8'd64, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0A01_0203, 32'h0A00_0005, 8'd64, PROTO_TCP, 2'd0, 4'd0, 1'b0));
        begin
            hdr_item_t it;
            it = random_item();
            it.mode = MODE_UNUSED;
            send_item(it);
        end
    endtask

    task automatic test_decisions();
        set_counts(5'd15, 5'd4);
        // bad header wins over everything
        send_item(packet_item(32'hC0A8_0001, 32'h0A00_0005, 8'd64, PROTO_ICMP, ICMP_ECHO_REQ,
                              4'd2, 1'b0));
        // echo reply leaves on the arrival port
        send_item(packet_item(32'hC0A8_0001, 32'h0A00_0005, 8'd64, PROTO_ICMP, ICMP_ECHO_REQ,
                              4'hF, 1'b1));
        // own address, icmp but not a valid echo request
        send_item(packet_item(32'h0A00_0001, 32'h0A00_0005, 8'd64, PROTO_ICMP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0A00_0001, 32'h0A00_0005, 8'd64, PROTO_ICMP, 2'd2, 4'd0, 1'b1));
        send_item(packet_item(32'h0A00_0001, 32'h0A00_0005, 8'd64, PROTO_ICMP, 2'd3, 4'd0, 1'b1));
        // own address, tcp and udp: port unreachable via source route
        send_item(packet_item(32'h0A01_0001, 32'h0A01_0203, 8'd0, PROTO_TCP, 2'd0, 4'd1, 1'b1));
        send_item(packet_item(32'h0A01_0001, 32'h0A01_0707, 8'd9, PROTO_UDP, 2'd0, 4'd1, 1'b1));
        // own address, other protocols
        send_item(packet_item(32'h0A01_0001, 32'h0A01_0707, 8'd9, 8'd255, 2'd1, 4'd1, 1'b1));
        send_item(packet_item(32'h0A01_0001, 32'h0A01_0707, 8'd9, 8'd0, 2'd1, 4'd1, 1'b1));
        // own address with no route back
        send_item(packet_item(32'hFFFF_FFFF, 32'h0808_0808, 8'd64, PROTO_TCP, 2'd0, 4'd3, 1'b1));
        // ttl zero and one expire
        send_item(packet_item(32'h0A01_0203, 32'hC0A8_0505, 8'd0, PROTO_UDP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0A01_0203, 32'hC0A8_0505, 8'd1, PROTO_UDP, 2'd0, 4'd0, 1'b1));
        // forwarding: host route, /24, /8, tie between equal masks
        send_item(packet_item(32'h0A01_0203, 32'hC0A8_0505, 8'd2, PROTO_UDP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0A01_0263, 32'hC0A8_0505, 8'd255, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0AC8_0001, 32'hC0A8_0505, 8'd64, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0A01_0909, 32'hC0A8_0505, 8'd64, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        // no destination route, then no route either way
        send_item(packet_item(32'h0808_0808, 32'h0A00_0005, 8'd64, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0000_0000, 32'h0000_0000, 8'd64, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        // default route in use
        set_counts(5'd16, 5'd4);
        send_item(packet_item(32'h0808_0808, 32'h0A00_0005, 8'd64, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0000_0000, 32'hFFFF_FFFF, 8'd64, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0808_0808, 32'h0102_0304, 8'd1, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        // upper interfaces out of use: not own, and no reply source for them
        set_counts(5'd16, 5'd2);
        send_item(packet_item(32'hC0A8_0001, 32'h0A00_0005, 8'd64, PROTO_ICMP, ICMP_ECHO_REQ,
                              4'd2, 1'b1));
        send_item(packet_item(32'h0808_0808, 32'hC0A8_0101, 8'd0, PROTO_TCP, 2'd0, 4'd0, 1'b1));
        send_item(packet_item(32'h0808_0808, 32'h0A01_0009, 8'd1, PROTO_TCP, 2'd0, 4'd0, 1'b1));
    endtask

    // extremes of both counts, including values past the table sizes
    task automatic test_count_sweep();
        logic [4:0] routes [6];
        logic [4:0] ports [6];
        routes = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd5, 5'd16};
        ports = '{5'd0, 5'd4, 5'd1, 5'd7, 5'd2, 5'd0};
        for (int s = 0; s < 6; s++) begin
            set_counts(routes[s], ports[s]);
            for (int k = 0; k < 25; k++)
                send_item(random_packet_item());
        end
    endtask

    task automatic test_random_traffic();
        for (int chunk = 0; chunk < 8; chunk++) begin
            if (chunk == 0)
                set_counts(5'd16, 5'd4);
            else
                set_counts(($urandom_range(99) < 70) ? $urandom_range(16, 10) : $urandom_range(16),
                           $urandom_range(4));
            no_stall = (chunk == 3);
            for (int k = 0; k < 205; k++) begin
                // hold the sender back until everything in flight has come out
                if (chunk == 5 && k == 100)
                    wait_drained();
                send_item(random_traffic_item());
            end
        end
        no_stall = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_table_load();
        test_decisions();
        test_count_sweep();
        test_random_traffic();
        wait_drained();
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0)
            $display("** ipv4_forward_decision_lpm: PASSED **");
        else
            $display("** ipv4_forward_decision_lpm: FAILED **");
        $finish;
    end

endmodule
